>>> rtl/xrp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xrp_pkg: shared types, constants and functions of the rotate PRNG
// Holds the operation codes, the jump tables, the state update and the
// command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package xrp_pkg;

  localparam int unsigned NumWords  = 8;
  localparam int unsigned WordWidth = 32;
  localparam int unsigned CountWidth = 8;

  // Operation codes of a request.
  typedef enum logic [1:0] {
    FUNC_DRAW      = 2'd0,
    FUNC_JUMP      = 2'd1,
    FUNC_LONG_JUMP = 2'd2,
    FUNC_LOAD_SEED = 2'd3
  } func_e;

  typedef logic [WordWidth-1:0] word_t;
  typedef logic [NumWords-1:0][WordWidth-1:0] gen_t;

  // Jump polynomials, word 7 first.
  localparam gen_t JumpTab = {
    32'h29b1661c, 32'h39abdc45, 32'he03fc9aa, 32'ha9582618,
    32'hf0c9392c, 32'hd5a61266, 32'h3cfd0aba, 32'h180ec6d3
  };
  localparam gen_t LongJumpTab = {
    32'h2acbe635, 32'h39109bb0, 32'h854ee241, 32'h77710069,
    32'h1c522fb3, 32'hc5004e44, 32'hfefdcbbf, 32'h76e15d3e
  };

  // Controller to datapath commands.
  typedef struct packed {
    logic load;       // write one seed word
    logic draw;       // produce an output and advance
    logic jump_start; // clear accumulators and the bit counter
    logic long_sel;   // jump start selects the long table
    logic jump_step;  // walk one table bit
    logic out_load;   // capture a result into the output register
  } cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic jump_last;  // the current table bit is the final one
  } status_t;

  // Rotate left by a constant amount.
  function automatic word_t rotl(input word_t v, input int unsigned n);
    rotl = (v << n) | (v >> (WordWidth - n));
  endfunction

  // Output word formed from the current state.
  function automatic word_t gen_output(input gen_t w);
    word_t a;
    word_t b;
    a = rotl(w[0] + w[6], 11) + w[0];
    b = rotl(w[1] + w[7], 13) + w[1];
    gen_output = a + b;
  endfunction

  // One step of the state update.
  function automatic gen_t gen_advance(input gen_t w);
    gen_t n;
    word_t sh2;
    word_t sh3;
    sh2 = w[2] << 7;
    sh3 = w[3] << 9;
    n[4] = w[4] ^ w[0];
    n[5] = w[5] ^ w[1];
    n[6] = w[6] ^ w[2];
    n[7] = w[7] ^ w[3];
    n[3] = w[3] ^ n[4];
    n[2] = w[2] ^ n[5];
    n[1] = w[1] ^ n[6];
    n[0] = w[0] ^ n[7];
    n[4] = n[4] ^ sh2;
    n[5] = n[5] ^ sh3;
    n[6] = rotl(n[6], 19);
    n[7] = rotl(n[7], 23);
    gen_advance = n;
  endfunction

  // Table bit selected by the walk counter: upper bits pick the word.
  function automatic logic jump_bit(input logic long_sel,
                                    input logic [CountWidth-1:0] idx);
    word_t w;
    if (long_sel) begin
      w = LongJumpTab[idx[7:5]];
    end else begin
      w = JumpTab[idx[7:5]];
    end
    jump_bit = w[idx[4:0]];
  endfunction

endpackage

>>> rtl/xrp_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xrp_req_if: request channel of the rotate PRNG
// Valid/ready handshake carrying the operation, seed index and seed word.
// ----------------------------------------------------------------------------
interface xrp_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [2:0]  word_index;
  logic [31:0] seed_word;

  modport source (output valid, output func, output word_index, output seed_word,
                  input ready);
  modport sink (input valid, input func, input word_index, input seed_word,
                output ready);
endinterface

>>> rtl/xrp_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xrp_rsp_if: result channel of the rotate PRNG
// Valid/ready handshake carrying one 32-bit random value.
// ----------------------------------------------------------------------------
interface xrp_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] random_value;

  modport source (output valid, output random_value, input ready);
  modport sink (input valid, input random_value, output ready);
endinterface

>>> rtl/xrp_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xrp_datapath: generator state, jump accumulators and result register
// Executes seed loads, draws and one table bit of a jump per step.
// ----------------------------------------------------------------------------
module xrp_datapath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  xrp_pkg::cmd_t     cmd_i,
  input  logic [2:0]        word_index_i,
  input  logic [31:0]       seed_word_i,
  output xrp_pkg::status_t  status_o,
  output logic [31:0]       random_value_o
);
  import xrp_pkg::*;

  gen_t                  gen_q, gen_d;
  gen_t                  accum_q, accum_d;
  logic [CountWidth-1:0] count_q, count_d;
  logic                  long_q, long_d;
  word_t                 rand_q;
  gen_t                  adv;
  word_t                 draw_val;

  assign adv      = gen_advance(gen_q);
  assign draw_val = gen_output(gen_q);

  // Next state of the generator and the jump walk.
  always_comb begin
    gen_d   = gen_q;
    accum_d = accum_q;
    count_d = count_q;
    long_d  = long_q;
    if (cmd_i.load) begin
      gen_d[word_index_i] = seed_word_i;
    end
    if (cmd_i.draw) begin
      gen_d = adv;
    end
    if (cmd_i.jump_start) begin
      accum_d = '0;
      count_d = '0;
      long_d  = cmd_i.long_sel;
    end
    if (cmd_i.jump_step) begin
      if (jump_bit(long_q, count_q)) begin
        accum_d = accum_q ^ gen_q;
      end
      count_d = count_q + 1'b1;
      // The final bit replaces the state with the accumulated result.
      gen_d = (count_q == '1) ? accum_d : adv;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gen_q   <= '0;
      accum_q <= '0;
      count_q <= '0;
      long_q  <= 1'b0;
    end else begin
      gen_q   <= gen_d;
      accum_q <= accum_d;
      count_q <= count_d;
      long_q  <= long_d;
    end
  end

  // Result register: draws return the output word, everything else zero.
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      rand_q <= cmd_i.draw ? draw_val : '0;
    end
  end

  assign status_o.jump_last = (count_q == '1);
  assign random_value_o     = rand_q;

endmodule

>>> rtl/xrp_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xrp_ctrl: request sequencer of the rotate PRNG
// Accepts requests, runs the 256-step jump walk and drives result valid.
// ----------------------------------------------------------------------------
module xrp_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              req_valid_i,
  output logic              req_ready_o,
  input  logic [1:0]        func_i,
  output logic              rsp_valid_o,
  input  logic              rsp_ready_i,
  input  xrp_pkg::status_t  status_i,
  output xrp_pkg::cmd_t     cmd_o
);
  import xrp_pkg::*;

  localparam logic StIdle = 1'b0;
  localparam logic StJump = 1'b1;

  logic  state_q, state_d;
  logic  out_valid_q, out_valid_d;
  logic  accept;
  func_e func;

  assign func = func_e'(func_i);

  // A request is taken only when idle and the result slot frees up.
  assign req_ready_o = (state_q == StIdle) && (!out_valid_q || rsp_ready_i);
  assign accept      = req_valid_i && req_ready_o;

  // Commands to the datapath.
  always_comb begin
    cmd_o            = '0;
    cmd_o.long_sel   = (func == FUNC_LONG_JUMP);
    cmd_o.jump_step  = (state_q == StJump);
    if (accept) begin
      unique case (func)
        FUNC_DRAW:      cmd_o.draw = 1'b1;
        FUNC_LOAD_SEED: cmd_o.load = 1'b1;
        FUNC_JUMP,
        FUNC_LONG_JUMP: cmd_o.jump_start = 1'b1;
        default:        cmd_o.load = 1'b0;
      endcase
    end
    cmd_o.out_load = cmd_o.draw || cmd_o.load || (cmd_o.jump_step && status_i.jump_last);
  end

  // Sequencer and result valid.
  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    if (rsp_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end
    unique case (state_q)
      StIdle: begin
        if (cmd_o.jump_start) begin
          state_d = StJump;
        end
      end
      StJump: begin
        if (status_i.jump_last) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign rsp_valid_o = out_valid_q;

endmodule

>>> rtl/xorshift_rotate_prng_256_jump.sv
`timescale 1ns / 1ps
// Draw and seed load give their result in the cycle after acceptance.
// Jump and long jump walk 256 table bits, one per cycle in the datapath, and
// give their result after the final bit; requests stall meanwhile.
// Throughput: one draw or seed load per cycle while results are taken.
// Reset: asynchronous, clears the state words, accumulators and bit counter.
// ----------------------------------------------------------------------------
// xorshift_rotate_prng_256_jump: 8x32-bit xor/shift/rotate generator
// Top level joining the request sequencer and the generator datapath.
// ----------------------------------------------------------------------------
module xorshift_rotate_prng_256_jump (
  input  logic      clk_i,
  input  logic      rst_ni,
  xrp_req_if.sink   req_i,
  xrp_rsp_if.source rsp_o
);
  import xrp_pkg::*;

  cmd_t    cmd;
  status_t status;

  xrp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .func_i      (req_i.func),
    .rsp_valid_o (rsp_o.valid),
    .rsp_ready_i (rsp_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  xrp_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .word_index_i   (req_i.word_index),
    .seed_word_i    (req_i.seed_word),
    .status_o       (status),
    .random_value_o (rsp_o.random_value)
  );

endmodule
